// ===== hw/rtl/tpchdc_pkg.sv =====
package tpchdc_pkg;

  localparam int PAD_GRIDS_DEF  = 16;
  localparam int TIME_GRIDS_DEF = 32;
  localparam int PAD_ROWS_DEF   = 45;
  localparam int MAX_ROWS       = 45;
  localparam int INNER_ROWS     = 13;
  localparam int EAST_MIN       = 12;

  localparam logic signed [31:0] DRIFT_LEN = 32'sd13677822;
  localparam logic signed [31:0] FAR_CM    = 32'sd655360000;
  localparam logic signed [31:0] GATE_IN   = 32'sd65536;
  localparam logic signed [31:0] GATE_OUT  = 32'sd91750;
  localparam logic [40:0]        Z_CAP     = 41'h10000000000;

  // corner value width and shared unit widths
  localparam int CW     = 36;
  localparam int MUL_AW = 38;
  localparam int MUL_BW = 33;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 32;
  localparam int DIV_CW = 7;

  localparam logic [7:0] PADS [MAX_ROWS] = '{
    8'd88, 8'd96, 8'd104, 8'd112, 8'd118, 8'd126, 8'd134, 8'd142, 8'd150, 8'd158,
    8'd166, 8'd174, 8'd182, 8'd98, 8'd100, 8'd102, 8'd104, 8'd106, 8'd106, 8'd108,
    8'd110, 8'd112, 8'd112, 8'd114, 8'd116, 8'd118, 8'd120, 8'd122, 8'd122, 8'd124,
    8'd126, 8'd128, 8'd128, 8'd130, 8'd132, 8'd134, 8'd136, 8'd138, 8'd138, 8'd140,
    8'd142, 8'd144, 8'd144, 8'd144, 8'd144};

  typedef enum logic [2:0] {
    CFG_SPACE_CHARGE  = 3'd0,
    CFG_DRIFT_VEL     = 3'd1,
    CFG_MAP_DRIFT_VEL = 3'd2,
    CFG_SECTOR_ID     = 3'd3,
    CFG_TB_GRID_SIZE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_HIT   = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_PAD,
    ST_DIV_TIME,
    ST_ADDR,
    ST_RD_BASE,
    ST_RD_SLOPE,
    ST_MUL_SC,
    ST_ADD_SC,
    ST_LERP_MUL,
    ST_LERP_ADD,
    ST_Z_PREP,
    ST_Z_MUL,
    ST_Z_DIVST,
    ST_Z_DIV,
    ST_OUT
  } st_e;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh7FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -48'sh80000000) r = -32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

endpackage

// ===== hw/rtl/tpchdc_if.sv =====
interface tpchdc_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic [17:0]        map_address;
  logic signed [31:0] map_value;
  logic [5:0]         pad_row;
  logic [15:0]        pad_position;
  logic [16:0]        time_bucket;

  modport source (output valid, op, map_address, map_value, pad_row, pad_position,
                  time_bucket, input ready);
  modport sink (input valid, op, map_address, map_value, pad_row, pad_position,
                time_bucket, output ready);
endinterface

interface tpchdc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_cm;
  logic signed [31:0] y_cm;
  logic signed [31:0] z_cm;
  logic               out_of_range;

  modport source (output valid, x_cm, y_cm, z_cm, out_of_range, input ready);
  modport sink (input valid, x_cm, y_cm, z_cm, out_of_range, output ready);
endinterface

// ===== hw/rtl/tpchdc_map_ram.sv =====
module tpchdc_map_ram #(
  parameter int DEPTH = 165240,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/tpchdc_mul.sv =====
module tpchdc_mul (
  input  logic                                   clk_i,
  input  logic signed [tpchdc_pkg::MUL_AW-1:0]   a_i,
  input  logic signed [tpchdc_pkg::MUL_BW-1:0]   b_i,
  output logic signed [tpchdc_pkg::MUL_PW-1:0]   p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= tpchdc_pkg::MUL_PW'(a_i) * tpchdc_pkg::MUL_PW'(b_i);
  end

endmodule

// ===== hw/rtl/tpchdc_div.sv =====
module tpchdc_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tpchdc_pkg::div_req_t req_i,
  output tpchdc_pkg::div_rsp_t rsp_o
);

  logic [tpchdc_pkg::DIV_CW-1:0] cnt_q;
  logic                          busy_q;
  logic                          done_q;
  logic [tpchdc_pkg::DIV_NW-1:0] quot_q;
  logic [tpchdc_pkg::DIV_DW-1:0] rem_q;
  logic [tpchdc_pkg::DIV_DW-1:0] div_q;
  logic [tpchdc_pkg::DIV_DW:0]   trial;
  logic                          fits;

  assign trial = {rem_q, quot_q[tpchdc_pkg::DIV_NW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        cnt_q  <= tpchdc_pkg::DIV_CW'(tpchdc_pkg::DIV_NW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == tpchdc_pkg::DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q <= req_i.dividend;
      rem_q  <= '0;
      div_q  <= req_i.divisor;
    end else if (busy_q) begin
      quot_q <= {quot_q[tpchdc_pkg::DIV_NW-2:0], fits};
      rem_q  <= fits ? tpchdc_pkg::DIV_DW'(trial - {1'b0, div_q})
                     : tpchdc_pkg::DIV_DW'(trial);
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hw/rtl/tpc_hit_distortion_correction_core.sv =====
// tpc hit distortion correction
// hit_i carries items: op 0 writes one word of the correction map (base and
// space-charge slope words per pad row, pad grid, time grid and axis), op 1
// corrects one hit and produces one item on res_o with x, y, z in cm and an
// out_of_range flag. configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i;
// the user writes it only while the block is idle; the block does not enforce this.
// a map write leaves the block idle, and the block is ready again next cycle.
// a hit takes these steps in order: the shared 64-step divider works out the pad grid
// and then the time grid, an address step follows, then map reads through the single
// memory read port with the shared multiplier (24 words), the z product, one more
// divider pass for the drift velocity rescale and the output step.
// an out-of-grid hit goes from the pad grid division straight to the output step.
// hit_i is not ready while a hit is in progress, so a new item is not taken before
// the last hit is through.
// the result sits in an output register; the next item is taken while it waits,
// and a finished hit holds in the core until res_o is free.
// reset clears the configuration to its defaults and drops any pending result;
// the map memory is not cleared and must be written before it is used.
module tpc_hit_distortion_correction_core #(
  parameter int PAD_GRIDS  = tpchdc_pkg::PAD_GRIDS_DEF,
  parameter int TIME_GRIDS = tpchdc_pkg::TIME_GRIDS_DEF,
  parameter int PAD_ROWS   = tpchdc_pkg::PAD_ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  tpchdc_in_if.sink           hit_i,
  tpchdc_out_if.source        res_o
);

  localparam int DEPTH   = PAD_ROWS * (PAD_GRIDS + 2) * (TIME_GRIDS + 2) * 6;
  localparam int AW      = $clog2(DEPTH);
  localparam int PGW     = $clog2(PAD_GRIDS + 2);
  localparam int TGW     = $clog2(TIME_GRIDS + 2);
  localparam int RPW     = $clog2(PAD_ROWS * (PAD_GRIDS + 2));
  localparam int STEP_PG = (TIME_GRIDS + 2) * 6;
  localparam int CW      = tpchdc_pkg::CW;

  // configuration
  logic signed [31:0] sc_q;
  logic [31:0]        dv_q;
  logic [31:0]        mdv_q;
  logic [4:0]         sector_q;
  logic [15:0]        tbgs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q     <= '0;
      dv_q     <= '0;
      mdv_q    <= 32'd16777216;
      sector_q <= '0;
      tbgs_q   <= 16'd4096;
    end else if (cfg_we_i) begin
      case (tpchdc_pkg::cfg_idx_e'(cfg_idx_i))
        tpchdc_pkg::CFG_SPACE_CHARGE:  sc_q     <= cfg_wdata_i;
        tpchdc_pkg::CFG_DRIFT_VEL:     dv_q     <= cfg_wdata_i;
        tpchdc_pkg::CFG_MAP_DRIFT_VEL: mdv_q    <= cfg_wdata_i;
        tpchdc_pkg::CFG_SECTOR_ID:     sector_q <= cfg_wdata_i[4:0];
        tpchdc_pkg::CFG_TB_GRID_SIZE:  tbgs_q   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  tpchdc_pkg::st_e state_q, state_d;

  logic                  accept;
  logic                  hit_acc;
  logic                  row_ok_in;
  logic [5:0]            pads_idx;
  logic                  row_ok_q;
  logic [5:0]            row_q;
  logic [16:0]           tb_q;
  logic [PGW-1:0]        ipg_q;
  logic [TGW-1:0]        tg_q;
  logic                  lin_q;
  logic [15:0]           dt_q;
  logic [15:0]           dp_q;
  logic [RPW-1:0]        rp_q;
  logic [AW-1:0]         cell_q;
  logic [1:0]            k_q;
  logic [1:0]            ls_q;
  logic [1:0]            j_q;
  logic signed [31:0]    base_q;
  logic signed [CW-1:0]  c_q [4];
  logic signed [CW-1:0]  la_q;
  logic signed [CW-1:0]  lb_q;
  logic signed [31:0]    xyz_q [3];
  logic signed [31:0]    z_q;
  logic                  oor_q;
  logic [31:0]           mag_q;
  logic                  mneg_q;
  logic                  out_valid_q;
  logic signed [31:0]    out_x_q, out_y_q, out_z_q;
  logic                  out_oor_q;

  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [31:0]           ram_rdata;
  logic signed [tpchdc_pkg::MUL_AW-1:0] mul_a;
  logic signed [tpchdc_pkg::MUL_BW-1:0] mul_b;
  logic signed [tpchdc_pkg::MUL_PW-1:0] mul_p;
  tpchdc_pkg::div_req_t  div_req;
  tpchdc_pkg::div_rsp_t  div_rsp;

  logic                  out_free;
  logic                  far;
  logic                  east;
  logic signed [31:0]    gate;
  logic [31:0]           vm;
  logic [AW-1:0]         corner_addr;
  logic signed [CW:0]    ldiff;
  logic signed [CW-1:0]  lbase;
  logic signed [tpchdc_pkg::MUL_PW-1:0] rnd28;
  logic signed [tpchdc_pkg::MUL_PW-1:0] rnd16;
  logic signed [CW+1:0]  lres;
  logic signed [34:0]    m_val;
  logic [64:0]           qr;
  logic [40:0]           qc;
  logic signed [41:0]    sq;
  logic signed [43:0]    zt;

  assign accept    = hit_i.valid && hit_i.ready;
  assign hit_acc   = accept && (hit_i.op == tpchdc_pkg::OP_HIT);
  assign ram_we    = accept && (hit_i.op == tpchdc_pkg::OP_WRITE)
                     && (32'(hit_i.map_address) < 32'(DEPTH));
  assign row_ok_in = (hit_i.pad_row >= 6'd1) && (32'(hit_i.pad_row) <= 32'(PAD_ROWS))
                     && (32'(hit_i.pad_row) <= 32'(tpchdc_pkg::MAX_ROWS));
  assign pads_idx  = row_ok_in ? hit_i.pad_row - 6'd1 : 6'd0;
  assign out_free  = !out_valid_q || res_o.ready;
  assign far       = (div_rsp.quot[63:16] > 48'(PAD_GRIDS)) || !row_ok_q || (tbgs_q == '0);
  assign east      = 32'(sector_q) > 32'(tpchdc_pkg::EAST_MIN);
  assign gate      = (32'(row_q) <= 32'(tpchdc_pkg::INNER_ROWS)) ? tpchdc_pkg::GATE_IN
                                                                 : tpchdc_pkg::GATE_OUT;
  assign vm        = (mdv_q == '0) ? 32'd1 : mdv_q;

  assign corner_addr = cell_q + (k_q[1] ? AW'(STEP_PG) : AW'(0))
                       + ((k_q[0] && !lin_q) ? AW'(6) : AW'(0))
                       + AW'({j_q, 1'b0});

  assign rnd28 = (mul_p + (tpchdc_pkg::MUL_PW'(1) <<< 27)) >>> 28;
  assign rnd16 = (mul_p + (tpchdc_pkg::MUL_PW'(1) <<< 15)) >>> 16;

  always_comb begin
    case (ls_q)
      2'd0:    ldiff = (CW+1)'(c_q[1]) - (CW+1)'(c_q[0]);
      2'd1:    ldiff = (CW+1)'(c_q[3]) - (CW+1)'(c_q[2]);
      default: ldiff = (CW+1)'(lb_q) - (CW+1)'(la_q);
    endcase
    case (ls_q)
      2'd0:    lbase = c_q[0];
      2'd1:    lbase = c_q[2];
      default: lbase = la_q;
    endcase
  end

  assign lres  = (CW+2)'(lbase) + (CW+2)'(rnd16);
  assign m_val = 35'(tpchdc_pkg::DRIFT_LEN) + 35'(gate)
                 + (east ? 35'(xyz_q[2]) : -35'(xyz_q[2]));

  assign qr = 65'(div_rsp.quot)
              + 65'({div_rsp.rem, 1'b0} >= {1'b0, vm});
  assign qc = (qr > 65'(tpchdc_pkg::Z_CAP)) ? tpchdc_pkg::Z_CAP : 41'(qr);
  assign sq = mneg_q ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  assign zt = east ? -(44'(tpchdc_pkg::DRIFT_LEN) - 44'(sq) + 44'(gate))
                   :  (44'(tpchdc_pkg::DRIFT_LEN) - 44'(sq) + 44'(gate));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpchdc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    hit_i.ready      = 1'b0;
    ram_raddr        = corner_addr;
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_q)
      tpchdc_pkg::ST_IDLE: begin
        hit_i.ready      = 1'b1;
        div_req.dividend = (64'(hit_i.pad_position) * 64'(PAD_GRIDS)) << 8;
        div_req.divisor  = 32'(tpchdc_pkg::PADS[pads_idx]);
        if (hit_acc) begin
          div_req.start = 1'b1;
          state_d       = tpchdc_pkg::ST_DIV_PAD;
        end
      end
      tpchdc_pkg::ST_DIV_PAD: begin
        div_req.dividend = 64'(tb_q) << 16;
        div_req.divisor  = 32'(tbgs_q);
        if (div_rsp.done) begin
          if (far) begin
            state_d = tpchdc_pkg::ST_OUT;
          end else begin
            div_req.start = 1'b1;
            state_d       = tpchdc_pkg::ST_DIV_TIME;
          end
        end
      end
      tpchdc_pkg::ST_DIV_TIME: begin
        if (div_rsp.done) state_d = tpchdc_pkg::ST_ADDR;
      end
      tpchdc_pkg::ST_ADDR:     state_d = tpchdc_pkg::ST_RD_BASE;
      tpchdc_pkg::ST_RD_BASE:  state_d = tpchdc_pkg::ST_RD_SLOPE;
      tpchdc_pkg::ST_RD_SLOPE: begin
        ram_raddr = corner_addr + AW'(1);
        state_d   = tpchdc_pkg::ST_MUL_SC;
      end
      tpchdc_pkg::ST_MUL_SC: begin
        mul_a   = tpchdc_pkg::MUL_AW'($signed(ram_rdata));
        mul_b   = tpchdc_pkg::MUL_BW'(sc_q);
        state_d = tpchdc_pkg::ST_ADD_SC;
      end
      tpchdc_pkg::ST_ADD_SC: begin
        state_d = (k_q == 2'd3) ? tpchdc_pkg::ST_LERP_MUL : tpchdc_pkg::ST_RD_BASE;
      end
      tpchdc_pkg::ST_LERP_MUL: begin
        mul_a   = tpchdc_pkg::MUL_AW'(ldiff);
        mul_b   = tpchdc_pkg::MUL_BW'($signed({1'b0, (ls_q == 2'd2) ? dp_q : dt_q}));
        state_d = tpchdc_pkg::ST_LERP_ADD;
      end
      tpchdc_pkg::ST_LERP_ADD: begin
        if (ls_q != 2'd2) state_d = tpchdc_pkg::ST_LERP_MUL;
        else if (j_q == 2'd2) state_d = tpchdc_pkg::ST_Z_PREP;
        else state_d = tpchdc_pkg::ST_RD_BASE;
      end
      tpchdc_pkg::ST_Z_PREP: state_d = tpchdc_pkg::ST_Z_MUL;
      tpchdc_pkg::ST_Z_MUL: begin
        mul_a   = $signed({6'd0, mag_q});
        mul_b   = $signed({1'b0, dv_q});
        state_d = tpchdc_pkg::ST_Z_DIVST;
      end
      tpchdc_pkg::ST_Z_DIVST: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_p[63:0];
        div_req.divisor  = vm;
        state_d          = tpchdc_pkg::ST_Z_DIV;
      end
      tpchdc_pkg::ST_Z_DIV: begin
        if (div_rsp.done) state_d = tpchdc_pkg::ST_OUT;
      end
      tpchdc_pkg::ST_OUT: begin
        if (out_free) state_d = tpchdc_pkg::ST_IDLE;
      end
      default: state_d = tpchdc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      ls_q <= '0;
      j_q  <= '0;
    end else begin
      case (state_q)
        tpchdc_pkg::ST_ADDR: begin
          k_q  <= '0;
          ls_q <= '0;
          j_q  <= '0;
        end
        tpchdc_pkg::ST_ADD_SC: begin
          k_q <= k_q + 2'd1;
        end
        tpchdc_pkg::ST_LERP_ADD: begin
          if (ls_q == 2'd2) begin
            ls_q <= '0;
            j_q  <= j_q + 2'd1;
          end else begin
            ls_q <= ls_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      tpchdc_pkg::ST_IDLE: begin
        if (hit_acc) begin
          row_ok_q <= row_ok_in;
          row_q    <= hit_i.pad_row;
          tb_q     <= hit_i.time_bucket;
        end
      end
      tpchdc_pkg::ST_DIV_PAD: begin
        ipg_q <= PGW'(div_rsp.quot[63:16]);
        dp_q  <= div_rsp.quot[15:0];
        oor_q <= far;
        if (far) begin
          xyz_q[0] <= tpchdc_pkg::FAR_CM;
          xyz_q[1] <= tpchdc_pkg::FAR_CM;
          z_q      <= tpchdc_pkg::FAR_CM;
        end
      end
      tpchdc_pkg::ST_DIV_TIME: begin
        rp_q <= RPW'(32'(row_q - 6'd1) * (PAD_GRIDS + 2) + 32'(ipg_q));
        if (div_rsp.quot[63:16] > 48'(TIME_GRIDS)) begin
          lin_q <= 1'b1;
          tg_q  <= TGW'(TIME_GRIDS + 1);
          dt_q  <= '0;
        end else begin
          lin_q <= 1'b0;
          tg_q  <= TGW'(div_rsp.quot[63:16]);
          dt_q  <= div_rsp.quot[15:0];
        end
      end
      tpchdc_pkg::ST_ADDR: begin
        cell_q <= AW'((32'(rp_q) * (TIME_GRIDS + 2) + 32'(tg_q)) * 6);
      end
      tpchdc_pkg::ST_RD_SLOPE: begin
        base_q <= ram_rdata;
      end
      tpchdc_pkg::ST_ADD_SC: begin
        c_q[k_q] <= CW'(base_q) + CW'(rnd28);
      end
      tpchdc_pkg::ST_LERP_ADD: begin
        case (ls_q)
          2'd0:    la_q <= CW'(lres);
          2'd1:    lb_q <= CW'(lres);
          default: xyz_q[j_q] <= tpchdc_pkg::sat32(48'(lres));
        endcase
      end
      tpchdc_pkg::ST_Z_PREP: begin
        mneg_q <= m_val < 0;
        mag_q  <= (m_val < 0) ? 32'(-m_val) : 32'(m_val);
      end
      tpchdc_pkg::ST_Z_DIV: begin
        if (div_rsp.done) z_q <= tpchdc_pkg::sat32(48'(zt));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == tpchdc_pkg::ST_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tpchdc_pkg::ST_OUT && out_free) begin
      out_x_q   <= xyz_q[0];
      out_y_q   <= xyz_q[1];
      out_z_q   <= z_q;
      out_oor_q <= oor_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.x_cm         = out_x_q;
  assign res_o.y_cm         = out_y_q;
  assign res_o.z_cm         = out_z_q;
  assign res_o.out_of_range = out_oor_q;

  tpchdc_map_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(hit_i.map_address)),
    .wdata_i (hit_i.map_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tpchdc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  tpchdc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

endmodule

// ===== hw/rtl/tpchdc_chk.sv =====
module tpchdc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_op_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_x_i,
  input logic [31:0] out_y_i,
  input logic [31:0] out_z_i,
  input logic        out_oor_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_far: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_oor_i |-> out_x_i == tpchdc_pkg::FAR_CM
      && out_y_i == tpchdc_pkg::FAR_CM && out_z_i == tpchdc_pkg::FAR_CM)
    else $error("out of range item without far coordinates");

  a_hit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i |=> !in_ready_i)
    else $error("ready after hit item");

  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_op_i |=> in_ready_i)
    else $error("not ready after map write");

endmodule

bind tpc_hit_distortion_correction_core tpchdc_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (hit_i.valid),
  .in_ready_i  (hit_i.ready),
  .in_op_i     (hit_i.op),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_x_i     (res_o.x_cm),
  .out_y_i     (res_o.y_cm),
  .out_z_i     (res_o.z_cm),
  .out_oor_i   (res_o.out_of_range)
);
